[sv/cdcs_pkg.sv]
`default_nettype none

package cdcs_pkg;

  // geometry
  localparam int MAX_TAPS    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int WEIGHT_REGS = 4;
  localparam int KTAP_W      = 3;
  localparam int WREG_IDX_W  = $clog2(WEIGHT_REGS);

  // datapath widths
  localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
  localparam int ABS_W  = (SAMPLE_BITS + 1 > 16) ? SAMPLE_BITS + 1 : 16;

  // fixed point constants
  localparam int PRE_SHIFT    = 14;
  localparam int PRE_ROUND    = 1 << (PRE_SHIFT - 1);
  localparam int ACT_SHIFT    = 15;
  localparam int ACT_ROUND    = 1 << (ACT_SHIFT - 1);
  localparam int SIG_ONE      = 32768;
  localparam int SIG_CLAMP    = 32768;
  localparam int INTERP_SHIFT = 11;
  localparam int INTERP_ROUND = 1 << (INTERP_SHIFT - 1);
  localparam int SIG_ENTRIES  = 17;
  localparam int SIG_IDX_W    = $clog2(SIG_ENTRIES);

  // sigmoid in Q1.15 at |x| = 0, 0.5, ... 8.0
  localparam logic [15:0] SIG_TABLE [SIG_ENTRIES] = '{
    16'd16384, 16'd20397, 16'd23955, 16'd26790, 16'd28862, 16'd30282,
    16'd31214, 16'd31808, 16'd32179, 16'd32408, 16'd32549, 16'd32635,
    16'd32687, 16'd32719, 16'd32738, 16'd32750, 16'd32757
  };

  // register file
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_KERNEL_TAPS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TAP_WEIGHT_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TAP_WEIGHT_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TAP_WEIGHT_2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TAP_WEIGHT_3 = 3'd4;

  localparam logic [KTAP_W-1:0] KERNEL_TAPS_RESET = 3'd4;

  // sequencing: accept, run the chain and activation pipe, hand over
  localparam int RUN_CYCLES = MAX_TAPS + 5;
  localparam int CNT_W      = $clog2(RUN_CYCLES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] preact_value;
    logic signed [SAMPLE_BITS-1:0] activation;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic                          en;
    logic signed [WEIGHT_BITS-1:0] weight;
  } tap_cfg_t;

endpackage

`default_nettype wire

[sv/cdcs_tap_cell.sv]
`default_nettype none

module cdcs_tap_cell
  import cdcs_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cell_ctrl_t                    ctrl,
  input  wire tap_cfg_t                      tap,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic                          valid_in,
  input  wire logic signed [ACC_W-1:0]       psum_in,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  output logic                               valid_out,
  output logic signed [ACC_W-1:0]            psum_out
);

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          valid_r;
  logic                          valid_nxt;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [ACC_W-1:0]       psum_r;
  logic signed [ACC_W-1:0]       psum_nxt;

  // a start flag drops the history this cell inherits
  assign valid_nxt = valid_in & ~ctrl.clear;

  always_comb begin
    if (tap.en && valid_r) begin
      prod_nxt = PROD_W'(sample_r) * PROD_W'(tap.weight);
    end else begin
      prod_nxt = '0;
    end
  end

  assign psum_nxt = psum_in + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.load) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_r <= sample_in;
    end
    prod_r <= prod_nxt;
    psum_r <= psum_nxt;
  end

  assign sample_out = sample_r;
  assign valid_out  = valid_r;
  assign psum_out   = psum_r;

endmodule

`default_nettype wire

[sv/cdcs_silu.sv]
`default_nettype none

module cdcs_silu
  import cdcs_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic signed [ACC_W-1:0]       acc,
  output logic signed [SAMPLE_BITS-1:0]      preact,
  output logic signed [SAMPLE_BITS-1:0]      act
);

  localparam int AP_W   = SAMPLE_BITS + 17;
  localparam int WIDE_W = 64;

  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed({{(WIDE_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (v < lo) begin
      sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_sample = v[SAMPLE_BITS-1:0];
    end
  endfunction

  // stage 1: round Q8.26 sum to Q4.12 and saturate
  logic signed [ACC_W:0]         rnd_pre;
  logic signed [ACC_W:0]         shr_pre;
  logic signed [SAMPLE_BITS-1:0] pre1_r;
  logic signed [SAMPLE_BITS-1:0] pre1_nxt;

  assign rnd_pre  = $signed({acc[ACC_W-1], acc}) + (ACC_W+1)'(PRE_ROUND);
  assign shr_pre  = rnd_pre >>> PRE_SHIFT;
  assign pre1_nxt = $signed(sat_sample(WIDE_W'(shr_pre)));

  // stage 2: table lookup and interpolation product
  logic                          neg1;
  logic [SAMPLE_BITS:0]          mag;
  logic [15:0]                   clamped;
  logic [SIG_IDX_W-1:0]          idx;
  logic [SIG_IDX_W-1:0]          idx_up;
  logic [INTERP_SHIFT-1:0]       frac;
  logic [15:0]                   base;
  logic [15:0]                   diff;
  logic [26:0]                   iprod_nxt;
  logic [26:0]                   iprod2_r;
  logic [15:0]                   base2_r;
  logic                          neg2_r;
  logic signed [SAMPLE_BITS-1:0] pre2_r;

  assign neg1 = pre1_r[SAMPLE_BITS-1];

  always_comb begin
    if (neg1) begin
      mag = -$unsigned((SAMPLE_BITS+1)'(pre1_r));
    end else begin
      mag = $unsigned((SAMPLE_BITS+1)'(pre1_r));
    end
    if (ABS_W'(mag) > ABS_W'(SIG_CLAMP)) begin
      clamped = 16'(SIG_CLAMP);
    end else begin
      clamped = 16'(mag);
    end
    idx  = clamped[15:INTERP_SHIFT];
    frac = clamped[INTERP_SHIFT-1:0];
    // the last entry has no right neighbour, so its slope is zero
    if (idx < SIG_IDX_W'(SIG_ENTRIES - 1)) begin
      idx_up = idx + SIG_IDX_W'(1);
    end else begin
      idx_up = idx;
    end
    base      = SIG_TABLE[idx];
    diff      = SIG_TABLE[idx_up] - base;
    iprod_nxt = 27'(diff) * 27'(frac);
  end

  // stage 3: finish the sigmoid, mirror for negative inputs
  logic [26:0]                   interp;
  logic [15:0]                   sig_nxt;
  logic [15:0]                   sig3_r;
  logic signed [SAMPLE_BITS-1:0] pre3_r;

  always_comb begin
    interp  = (iprod2_r + 27'(INTERP_ROUND)) >> INTERP_SHIFT;
    sig_nxt = base2_r + 16'(interp);
    if (neg2_r) begin
      sig_nxt = 16'(SIG_ONE) - sig_nxt;
    end
  end

  // stage 4: preact times sigmoid
  logic signed [AP_W-1:0]        aprod_nxt;
  logic signed [AP_W-1:0]        aprod4_r;
  logic signed [SAMPLE_BITS-1:0] pre4_r;

  assign aprod_nxt = AP_W'(pre3_r) * AP_W'($signed({1'b0, sig3_r}));

  always_ff @(posedge clk) begin
    pre1_r   <= pre1_nxt;
    pre2_r   <= pre1_r;
    neg2_r   <= neg1;
    base2_r  <= base;
    iprod2_r <= iprod_nxt;
    pre3_r   <= pre2_r;
    sig3_r   <= sig_nxt;
    pre4_r   <= pre3_r;
    aprod4_r <= aprod_nxt;
  end

  logic signed [AP_W:0] rnd_act;
  logic signed [AP_W:0] shr_act;

  assign rnd_act = $signed({aprod4_r[AP_W-1], aprod4_r}) + (AP_W+1)'(ACT_ROUND);
  assign shr_act = rnd_act >>> ACT_SHIFT;
  assign act     = $signed(sat_sample(WIDE_W'(shr_act)));
  assign preact  = pre4_r;

endmodule

`default_nettype wire

[sv/causal_depthwise_conv_silu_core.sv]
`default_nettype none

// Causal depthwise 1-D convolution with SiLU for one channel lane. Samples and
// results are Q4.12, tap weights Q2.14; a token flagged first_of_sequence drops
// all earlier history. Each token gives one transaction carrying the saturated
// pre-activation and pre-activation times a table-interpolated sigmoid. The
// block takes one token at a time: a token occupies it while the partial sum
// walks the chain of tap cells one cell per cycle and then the four-stage
// activation pipe; while a result is stalled at the output the following token
// still runs, but its result then waits and holds off any further token until
// the output is taken.
// Registers sit at byte address 4*i: kernel_taps, then tap_weight_0..3; write
// them only while the block is idle.

module causal_depthwise_conv_silu_core
  import cdcs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  // configuration registers
  logic [KTAP_W-1:0]                                 kernel_r;
  logic [WEIGHT_REGS-1:0][WEIGHT_BITS-1:0]           weights_r;
  logic [REG_IDX_W-1:0]                              reg_idx;
  logic                                              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r  <= KERNEL_TAPS_RESET;
      weights_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KERNEL_TAPS:  kernel_r     <= pwdata[KTAP_W-1:0];
        REG_TAP_WEIGHT_0: weights_r[0] <= pwdata[WEIGHT_BITS-1:0];
        REG_TAP_WEIGHT_1: weights_r[1] <= pwdata[WEIGHT_BITS-1:0];
        REG_TAP_WEIGHT_2: weights_r[2] <= pwdata[WEIGHT_BITS-1:0];
        REG_TAP_WEIGHT_3: weights_r[3] <= pwdata[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KERNEL_TAPS:  prdata = PDATA_W'(kernel_r);
      REG_TAP_WEIGHT_0: prdata = PDATA_W'($signed(weights_r[0]));
      REG_TAP_WEIGHT_1: prdata = PDATA_W'($signed(weights_r[1]));
      REG_TAP_WEIGHT_2: prdata = PDATA_W'($signed(weights_r[2]));
      REG_TAP_WEIGHT_3: prdata = PDATA_W'($signed(weights_r[3]));
      default:          prdata = '0;
    endcase
  end

  // sequencer
  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             accept;
  logic             run_done;
  logic             out_load;

  assign accept   = in_valid & ~in_stall;
  assign run_done = (cnt_r == CNT_W'(RUN_CYCLES - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RUN;
      ST_RUN:  if (run_done) state_nxt = ST_HOLD;
      ST_HOLD: if (!out_valid || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    cnt_nxt  = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cnt_nxt  = '0;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_HOLD: begin
        out_load = ~out_valid | ~out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // tap mapping: cell i holds the sample i tokens back and meets weight k-1-i
  logic [KTAP_W-1:0] k_eff;

  assign k_eff = ({1'b0, kernel_r} > (KTAP_W+1)'(MAX_TAPS)) ? KTAP_W'(MAX_TAPS) : kernel_r;

  logic signed [SAMPLE_BITS-1:0] samp_chain  [MAX_TAPS];
  logic                          valid_chain [MAX_TAPS];
  logic signed [ACC_W-1:0]       psum_chain  [MAX_TAPS];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TAPS; gi++) begin : g_cell
      localparam logic [KTAP_W-1:0] CELL_IDX = KTAP_W'(gi);
      logic [KTAP_W-1:0]             tap_j;
      tap_cfg_t                      tap;
      cell_ctrl_t                    ctrl;
      logic signed [SAMPLE_BITS-1:0] s_in;
      logic                          v_in;
      logic signed [ACC_W-1:0]       p_in;

      assign tap_j  = k_eff - CELL_IDX - KTAP_W'(1);
      assign tap.en = (CELL_IDX < k_eff);
      assign tap.weight = (tap_j < KTAP_W'(WEIGHT_REGS)) ?
                          $signed(weights_r[tap_j[WREG_IDX_W-1:0]]) : '0;
      assign ctrl.load = accept;

      if (gi == 0) begin : g_head
        // the current token always counts
        assign ctrl.clear = 1'b0;
        assign s_in       = in_data.sample;
        assign v_in       = 1'b1;
        assign p_in       = '0;
      end else begin : g_body
        assign ctrl.clear = in_data.first_of_sequence;
        assign s_in       = samp_chain[gi-1];
        assign v_in       = valid_chain[gi-1];
        assign p_in       = psum_chain[gi-1];
      end

      cdcs_tap_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .tap        (tap),
        .sample_in  (s_in),
        .valid_in   (v_in),
        .psum_in    (p_in),
        .sample_out (samp_chain[gi]),
        .valid_out  (valid_chain[gi]),
        .psum_out   (psum_chain[gi])
      );
    end
  endgenerate

  logic signed [SAMPLE_BITS-1:0] preact;
  logic signed [SAMPLE_BITS-1:0] act;

  cdcs_silu u_silu (
    .clk    (clk),
    .acc    (psum_chain[MAX_TAPS-1]),
    .preact (preact),
    .act    (act)
  );

  // output register
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;

  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.preact_value <= preact;
      out_data_r.activation   <= act;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN) && (cnt_r == '0))
    else $error("accepted transaction did not start the run");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r < CNT_W'(RUN_CYCLES)))
    else $error("run counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && out_valid_r && out_stall) |=> (state_r == ST_HOLD))
    else $error("result left hold while output slot was occupied");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_head_cell_valid: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> valid_chain[0])
    else $error("current sample not marked valid in head cell");

endmodule

`default_nettype wire

[bench/tb_causal_depthwise_conv_silu_core.sv]
`timescale 1ns / 100ps

module tb_causal_depthwise_conv_silu_core;
  import cdcs_pkg::*;

  localparam int TOKEN_CYCLES = MAX_TAPS + 7;
  localparam int CYCLE_LIMIT  = 1000000;

  // register slots past the last weight, writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  // sigmoid breakpoints, Q1.15 at |x| = 0, 0.5 ... 8.0
  localparam int LOGISTIC_Q15 [17] = '{
    16384, 20397, 23955, 26790, 28862, 30282, 31214, 31808, 32179,
    32408, 32549, 32635, 32687, 32719, 32738, 32750, 32757
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // predictor copy of the lane
  logic [KTAP_W-1:0]             ntaps = KERNEL_TAPS_RESET;
  logic signed [WEIGHT_BITS-1:0] tap_w [WEIGHT_REGS] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] tap_hist [MAX_TAPS-1] = '{default: '0};
  int                            hist_len = 0;

  out_item_t silu_results_due [$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_req        = 0;
  int hold_left       = 0;
  int errors_seen     = 0;
  int tokens_sent     = 0;
  int results_checked = 0;
  int cycle_no        = 0;

  causal_depthwise_conv_silu_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_no,
               silu_results_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint sat_q412(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint logistic_q15(longint v);
    longint mag;
    longint frac;
    longint s;
    int     idx;
    mag = (v < 0) ? -v : v;
    if (mag > 32768) mag = 32768;
    idx  = int'(mag >> 11);
    frac = mag & 2047;
    s    = LOGISTIC_Q15[idx];
    if (idx < 16)
      s += ((LOGISTIC_Q15[idx+1] - LOGISTIC_Q15[idx]) * frac + 1024) >> 11;
    return (v < 0) ? 32768 - s : s;
  endfunction

  // one token through the lane: conv sum, rounding, silu, then history shift
  function automatic out_item_t compute_conv_silu(logic signed [SAMPLE_BITS-1:0] smp,
                                                  logic fos);
    longint    acc;
    longint    pre;
    longint    act;
    longint    src;
    int        k;
    int        lag;
    out_item_t r;
    k = (ntaps > MAX_TAPS) ? MAX_TAPS : int'(ntaps);
    if (fos) hist_len = 0;
    acc = 0;
    for (int j = 0; j < k; j++) begin
      lag = k - 1 - j;
      if (lag == 0) begin
        src = smp;
      end else if (lag <= hist_len) begin
        src = tap_hist[lag-1];
      end else begin
        continue;
      end
      acc += src * longint'(tap_w[j]);
    end
    pre = sat_q412((acc + (64'sd1 <<< (PRE_SHIFT - 1))) >>> PRE_SHIFT);
    act = sat_q412((pre * logistic_q15(pre) + (64'sd1 <<< (ACT_SHIFT - 1))) >>> ACT_SHIFT);
    for (int i = MAX_TAPS - 2; i > 0; i--) tap_hist[i] = tap_hist[i-1];
    tap_hist[0] = smp;
    if (hist_len < MAX_TAPS - 1) hist_len++;
    r.preact_value = pre[SAMPLE_BITS-1:0];
    r.activation   = act[SAMPLE_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [15:0] rand_q16();
    int v;
    case ($urandom_range(15))
      0:          v = 32767;
      1:          v = -32768;
      2:          v = 0;
      3, 4, 5, 6: v = int'($urandom_range(8192)) - 4096;
      7, 8, 9:    v = int'($urandom_range(40000)) - 20000;
      default:    v = int'($urandom);
    endcase
    return v[15:0];
  endfunction

  // result side: check each transaction, then pick the stall for the next cycle
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (silu_results_due.size() == 0) begin
        $error("result with nothing outstanding: preact_value %0d activation %0d",
               out_data.preact_value, out_data.activation);
        errors_seen++;
      end else begin
        want = silu_results_due.pop_front();
        if (out_data.preact_value !== want.preact_value) begin
          $error("preact_value: expected %0d, got %0d", want.preact_value,
                 out_data.preact_value);
          errors_seen++;
        end
        if (out_data.activation !== want.activation) begin
          $error("activation: expected %0d, got %0d", want.activation,
                 out_data.activation);
          errors_seen++;
        end
      end
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KERNEL_TAPS:  ntaps    = val[KTAP_W-1:0];
      REG_TAP_WEIGHT_0: tap_w[0] = val[WEIGHT_BITS-1:0];
      REG_TAP_WEIGHT_1: tap_w[1] = val[WEIGHT_BITS-1:0];
      REG_TAP_WEIGHT_2: tap_w[2] = val[WEIGHT_BITS-1:0];
      REG_TAP_WEIGHT_3: tap_w[3] = val[WEIGHT_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_weights(input logic signed [15:0] w0, input logic signed [15:0] w1,
                               input logic signed [15:0] w2, input logic signed [15:0] w3);
    write_reg(REG_TAP_WEIGHT_0, {{16{w0[15]}}, w0});
    write_reg(REG_TAP_WEIGHT_1, {{16{w1[15]}}, w1});
    write_reg(REG_TAP_WEIGHT_2, {{16{w2[15]}}, w2});
    write_reg(REG_TAP_WEIGHT_3, {{16{w3[15]}}, w3});
  endtask

  // valid stays up after acceptance; the next call or quiesce decides what follows
  task automatic push_token(input logic signed [SAMPLE_BITS-1:0] smp, input logic fos);
    in_item_t item;
    item.sample            = smp;
    item.first_of_sequence = fos;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    silu_results_due.push_back(compute_conv_silu(smp, fos));
    tokens_sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (silu_results_due.size() != 0) @(posedge clk);
  endtask

  // mostly flagged sequences with random content, some stray or missing flags
  task automatic stream_sequences(input int count);
    int   left;
    int   seq_len;
    logic fos;
    left = count;
    while (left > 0) begin
      seq_len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
      for (int n = 0; n < seq_len && left > 0; n++) begin
        fos = (n == 0);
        if ($urandom_range(19) == 0) fos = !fos;
        push_token(rand_q16(), fos);
        left--;
      end
    end
    quiesce();
  endtask

  task automatic load_random_config();
    logic [KTAP_W-1:0]  k;
    logic [PDATA_W-1:0] junk;
    case ($urandom_range(19))
      0, 1:    k = '0;
      2, 3, 4: k = KTAP_W'($urandom_range(7, 5));
      default: k = KTAP_W'($urandom_range(4, 1));
    endcase
    // upper bits beyond the register width must not matter
    junk = $urandom_range(1) ? $urandom : '0;
    write_reg(REG_KERNEL_TAPS, {junk[PDATA_W-1:KTAP_W], k});
    write_reg(REG_TAP_WEIGHT_0, {junk[PDATA_W-1:16], rand_q16()});
    write_reg(REG_TAP_WEIGHT_1, {junk[PDATA_W-1:16], rand_q16()});
    write_reg(REG_TAP_WEIGHT_2, {junk[PDATA_W-1:16], rand_q16()});
    write_reg(REG_TAP_WEIGHT_3, {junk[PDATA_W-1:16], rand_q16()});
    if ($urandom_range(3) == 0)
      write_reg(REG_IDX_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)), $urandom);
  endtask

  // kernel_taps left at its reset value, only the weights are loaded
  task automatic test_reset_kernel();
    write_weights(16'sd4096, -16'sd8192, 16'sd12288, 16'sd16384);
    push_token(16'sd4096, 1'b1);
    push_token(-16'sd4096, 1'b0);
    push_token(16'sd32767, 1'b0);
    push_token(-16'sd32768, 1'b0);
    push_token(16'sd100, 1'b0);
    quiesce();
  endtask

  // full-scale weights and samples, saturation both ways, restart mid sequence
  task automatic test_extreme_products();
    write_weights(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    push_token(-16'sd32768, 1'b1);
    push_token(-16'sd32768, 1'b0);
    push_token(-16'sd32768, 1'b0);
    push_token(-16'sd32768, 1'b0);
    quiesce();
    write_weights(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    push_token(-16'sd32768, 1'b1);
    push_token(-16'sd32768, 1'b0);
    push_token(16'sd32767, 1'b1);
    push_token(16'sd32767, 1'b0);
    quiesce();
  endtask

  // zero taps, sizes one to three, and sizes above the tap count
  task automatic test_kernel_sizes();
    logic [KTAP_W-1:0] sizes [6] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd7};
    write_weights(16'sd16384, 16'sd8192, -16'sd16384, 16'sd4096);
    foreach (sizes[i]) begin
      if (sizes[i] == 3'd7) begin
        write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED_HI, 32'h8000_7FFF);
      end
      write_reg(REG_KERNEL_TAPS, {{(PDATA_W-KTAP_W){1'b0}}, sizes[i]});
      push_token(rand_q16(), 1'b1);
      push_token(rand_q16(), 1'b0);
      quiesce();
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int c = 0; c < 3; c++) begin
        load_random_config();
        stream_sequences(150);
      end
    end
  endtask

  // long output hold while tokens keep coming, so the lane backs up to its input
  task automatic test_output_backpressure();
    load_random_config();
    write_reg(REG_KERNEL_TAPS, {{(PDATA_W-KTAP_W){1'b0}}, 3'd4});
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 300;
    stream_sequences(30);
    recv_stall_pct = 62;
    stream_sequences(30);
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_kernel();
    test_extreme_products();
    test_kernel_sizes();
    test_random_traffic();
    test_output_backpressure();
    repeat (2 * TOKEN_CYCLES) @(posedge clk);
    if (silu_results_due.size() != 0) begin
      $error("%0d expected results never arrived", silu_results_due.size());
      errors_seen++;
    end
    $display("%0d tokens sent, %0d results checked, %0d mismatches", tokens_sent,
             results_checked, errors_seen);
    $display("kernel sizes 0 to 7, sequence restarts, saturation, idle and stall mixes");
    if (errors_seen == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
